FILE: rtl/absp_pkg.sv
// Shared types and constants for the box subtract-and-split block.
// Used by absp_front, absp_queue, absp_back and axis_box_subtract_split.
// No dependencies.
`default_nettype none

package absp_pkg;

   // Coordinate and index widths (signed Q16.16 coordinates)
   localparam int COORD_BITS     = 32;
   localparam int INDEX_BITS     = 16;

   // Up to six pieces: lower and upper side on each of three axes
   localparam int NUM_AXES       = 3;
   localparam int NUM_PIECES     = 2 * NUM_AXES;
   localparam int PIECE_SEL_BITS = $clog2(NUM_PIECES);
   localparam int PIECE_NUM_BITS = 3;

   // Queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

   // Register file
   localparam int CSR_INDEX_BITS = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [INDEX_BITS-1:0]        index_type;
   typedef logic [CSR_INDEX_BITS-1:0]    csr_index_type;
   typedef coord_type [NUM_AXES-1:0]     vec3_type;

   // Register indexes
   localparam csr_index_type CSR_SUB_MIN_X = CSR_INDEX_BITS'(0);
   localparam csr_index_type CSR_SUB_MIN_Y = CSR_INDEX_BITS'(1);
   localparam csr_index_type CSR_SUB_MIN_Z = CSR_INDEX_BITS'(2);
   localparam csr_index_type CSR_SUB_MAX_X = CSR_INDEX_BITS'(3);
   localparam csr_index_type CSR_SUB_MAX_Y = CSR_INDEX_BITS'(4);
   localparam csr_index_type CSR_SUB_MAX_Z = CSR_INDEX_BITS'(5);

   // Classified request waiting for the back end
   typedef struct packed {
      index_type                index;
      vec3_type                 box_lo;
      vec3_type                 box_hi;
      vec3_type                 cut_lo;
      vec3_type                 cut_hi;
      logic [NUM_PIECES-1:0]    piece_mask;
   } work_type;

   // One result item
   typedef struct packed {
      index_type                  index;
      logic                       piece_valid;
      logic [PIECE_NUM_BITS-1:0]  piece_number;
      vec3_type                   lo;
      vec3_type                   hi;
      logic                       last_piece;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/absp_front.sv
// Front end: subtract box registers, intersection test and piece classification.
// Depends on absp_pkg.
`default_nettype none

module absp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  absp_pkg::csr_index_type csr_index,
   input  absp_pkg::coord_type    csr_wdata,
   input  logic                   req_push,
   input  absp_pkg::index_type    req_index,
   input  absp_pkg::vec3_type     req_lo,
   input  absp_pkg::vec3_type     req_hi,
   input  logic                   q_full,
   output logic                   q_push,
   output absp_pkg::work_type     q_wdata
);
   import absp_pkg::*;

   vec3_type              sub_lo_ff, sub_lo_in;
   vec3_type              sub_hi_ff, sub_hi_in;
   vec3_type              cut_lo;
   vec3_type              cut_hi;
   logic [NUM_AXES-1:0]   overlap;
   logic [NUM_PIECES-1:0] mask;

   // Register writes
   always_comb begin
      sub_lo_in = sub_lo_ff;
      sub_hi_in = sub_hi_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SUB_MIN_X: sub_lo_in[0] = csr_wdata;
            CSR_SUB_MIN_Y: sub_lo_in[1] = csr_wdata;
            CSR_SUB_MIN_Z: sub_lo_in[2] = csr_wdata;
            CSR_SUB_MAX_X: sub_hi_in[0] = csr_wdata;
            CSR_SUB_MAX_Y: sub_hi_in[1] = csr_wdata;
            CSR_SUB_MAX_Z: sub_hi_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_lo_ff <= '0;
         sub_hi_ff <= '0;
      end else begin
         sub_lo_ff <= sub_lo_in;
         sub_hi_ff <= sub_hi_in;
      end
   end

   // Intersection per axis; a side piece exists where the box sticks out
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         cut_lo[a] = ($signed(sub_lo_ff[a]) > $signed(req_lo[a])) ? sub_lo_ff[a] : req_lo[a];
         cut_hi[a] = ($signed(sub_hi_ff[a]) < $signed(req_hi[a])) ? sub_hi_ff[a] : req_hi[a];
         overlap[a]    = $signed(cut_lo[a]) < $signed(cut_hi[a]);
         mask[2*a]     = $signed(sub_lo_ff[a]) > $signed(req_lo[a]);
         mask[2*a + 1] = $signed(sub_hi_ff[a]) < $signed(req_hi[a]);
      end
   end

   // Only boxes that meet the subtract box go on to the back end
   assign q_push             = req_push && !q_full && (&overlap);
   assign q_wdata.index      = req_index;
   assign q_wdata.box_lo     = req_lo;
   assign q_wdata.box_hi     = req_hi;
   assign q_wdata.cut_lo     = cut_lo;
   assign q_wdata.cut_hi     = cut_hi;
   assign q_wdata.piece_mask = mask;

endmodule

`default_nettype wire

FILE: rtl/absp_queue.sv
// Short queue of classified requests between front and back end.
// Depends on absp_pkg.
`default_nettype none

module absp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  absp_pkg::work_type wdata,
   input  logic               pop,
   output absp_pkg::work_type rdata,
   output logic               full,
   output logic               empty
);
   import absp_pkg::*;

   work_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
   endfunction

   assign full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + QCNT_BITS'(1);
      else if (pop && !push)
         count_in = count_ff - QCNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= wdata;
   end

endmodule

`default_nettype wire

FILE: rtl/absp_back.sv
// Back end: walks the piece mask of the head request, one result per cycle while
// the output is free, into a registered output stage. Depends on absp_pkg.
`default_nettype none

module absp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  absp_pkg::work_type   q_head,
   output logic                 q_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output absp_pkg::result_type result
);
   import absp_pkg::*;

   logic                       busy_ff, busy_in;
   logic [NUM_PIECES-1:0]      rem_ff, rem_in;
   logic [PIECE_NUM_BITS-1:0]  num_ff, num_in;
   logic                       out_valid_ff, out_valid_in;
   result_type                 out_ff, out_in;

   logic                       out_free;
   logic                       fire;
   logic [NUM_PIECES-1:0]      work_mask;
   logic [NUM_PIECES-1:0]      rem_next;
   logic [PIECE_SEL_BITS-1:0]  sel;
   logic [PIECE_NUM_BITS-1:0]  cur_num;
   result_type                 res_next;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign fire      = out_free && !q_empty;
   assign work_mask = busy_ff ? rem_ff : q_head.piece_mask;
   assign cur_num   = busy_ff ? num_ff : '0;

   // Lowest remaining piece goes first
   always_comb begin
      sel = '0;
      for (int j = NUM_PIECES - 1; j >= 0; j--) begin
         if (work_mask[j])
            sel = PIECE_SEL_BITS'(j);
      end
   end

   assign rem_next = work_mask & ~(NUM_PIECES'(1) << sel);

   // Build the result: box with one side moved to the cut on the chosen axis
   always_comb begin
      res_next       = '0;
      res_next.index = q_head.index;
      if (work_mask == '0) begin
         // box fully covered: single removal marker
         res_next.last_piece = 1'b1;
      end else begin
         res_next.piece_valid  = 1'b1;
         res_next.piece_number = cur_num;
         res_next.last_piece   = (rem_next == '0);
         for (int a = 0; a < NUM_AXES; a++) begin
            res_next.lo[a] = q_head.box_lo[a];
            res_next.hi[a] = q_head.box_hi[a];
            if (sel == PIECE_SEL_BITS'(2*a))
               res_next.hi[a] = q_head.cut_lo[a];
            if (sel == PIECE_SEL_BITS'(2*a + 1))
               res_next.lo[a] = q_head.cut_hi[a];
         end
      end
   end

   assign q_pop = fire && ((work_mask == '0) || (rem_next == '0));

   // Next state
   always_comb begin
      busy_in      = busy_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      if (fire) begin
         busy_in      = !q_pop;
         rem_in       = rem_next;
         num_in       = cur_num + PIECE_NUM_BITS'(1);
         out_valid_in = 1'b1;
         out_in       = res_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rem_ff       <= '0;
         num_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rem_ff       <= rem_in;
         num_ff       <= num_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign result    = out_ff;

endmodule

`default_nettype wire

FILE: rtl/axis_box_subtract_split.sv
// Box subtract-and-split: an accepted request is written to the queue, and its first
// result is registered in the back-end output stage. The back end issues one result
// per cycle while its output is free, 1 to 6 per request; requests that miss the
// subtract box take no back-end time. A 4-entry queue decouples front and back.
// Synchronous active-high reset clears the subtract box to zero and empties the queue.
// Depends on absp_pkg, absp_front, absp_queue, absp_back.
`default_nettype none

module axis_box_subtract_split (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_write_enable,
   input  absp_pkg::csr_index_type       csr_index,
   input  absp_pkg::coord_type           csr_wdata,
   // requests
   input  logic                          req_push,
   output logic                          req_full,
   input  absp_pkg::index_type           req_box_index,
   input  absp_pkg::coord_type           req_box_min_x,
   input  absp_pkg::coord_type           req_box_min_y,
   input  absp_pkg::coord_type           req_box_min_z,
   input  absp_pkg::coord_type           req_box_max_x,
   input  absp_pkg::coord_type           req_box_max_y,
   input  absp_pkg::coord_type           req_box_max_z,
   // results
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output absp_pkg::index_type           rsp_source_index,
   output logic                          rsp_piece_valid,
   output logic [absp_pkg::PIECE_NUM_BITS-1:0] rsp_piece_number,
   output absp_pkg::coord_type           rsp_piece_min_x,
   output absp_pkg::coord_type           rsp_piece_min_y,
   output absp_pkg::coord_type           rsp_piece_min_z,
   output absp_pkg::coord_type           rsp_piece_max_x,
   output absp_pkg::coord_type           rsp_piece_max_y,
   output absp_pkg::coord_type           rsp_piece_max_z,
   output logic                          rsp_last_piece
);
   import absp_pkg::*;

   vec3_type   req_lo;
   vec3_type   req_hi;
   logic       q_push;
   logic       q_pop;
   logic       q_full;
   logic       q_empty;
   work_type   q_wdata;
   work_type   q_head;
   result_type result;

   assign req_lo[0] = req_box_min_x;
   assign req_lo[1] = req_box_min_y;
   assign req_lo[2] = req_box_min_z;
   assign req_hi[0] = req_box_max_x;
   assign req_hi[1] = req_box_max_y;
   assign req_hi[2] = req_box_max_z;
   assign req_full  = q_full;

   absp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_index        (req_box_index),
      .req_lo           (req_lo),
      .req_hi           (req_hi),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_wdata          (q_wdata)
   );

   absp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_head),
      .full  (q_full),
      .empty (q_empty)
   );

   absp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .result    (result)
   );

   // Result ports
   assign rsp_source_index = result.index;
   assign rsp_piece_valid  = result.piece_valid;
   assign rsp_piece_number = result.piece_number;
   assign rsp_piece_min_x  = result.lo[0];
   assign rsp_piece_min_y  = result.lo[1];
   assign rsp_piece_min_z  = result.lo[2];
   assign rsp_piece_max_x  = result.hi[0];
   assign rsp_piece_max_y  = result.hi[1];
   assign rsp_piece_max_z  = result.hi[2];
   assign rsp_last_piece   = result.last_piece;

   // Checks
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end popped an empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("front end pushed into a full queue");

   a_removed_marker: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_piece_valid) |-> (rsp_last_piece && rsp_piece_number == '0))
      else $error("removal result not marked last or numbered non-zero");

   a_piece_nonempty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_piece_valid) |->
         ($signed(rsp_piece_min_x) < $signed(rsp_piece_max_x) &&
          $signed(rsp_piece_min_y) < $signed(rsp_piece_max_y) &&
          $signed(rsp_piece_min_z) < $signed(rsp_piece_max_z)))
      else $error("emitted piece is empty");

endmodule

`default_nettype wire

FILE: bench/tb_axis_box_subtract_split.sv
// Self-checking testbench for axis_box_subtract_split: queue-style request and result
// channels, register writes between phases, and a built-in prediction of every piece.
// Depends on absp_pkg and the axis_box_subtract_split RTL.
`default_nettype none

module tb_axis_box_subtract_split;
   timeunit 1ns;
   timeprecision 1ps;

   import absp_pkg::*;

   localparam int        Q_ONE         = 65536;      // 1.0 in Q16.16
   localparam int        RESET_CYCLES  = 12;
   localparam int        DRAIN_CYCLES  = 20;
   localparam int        CYCLE_LIMIT   = 200000;
   localparam int        PHASE_ITEMS   = 25;
   localparam coord_type COORD_LOWEST  = coord_type'(32'h8000_0000);
   localparam coord_type COORD_HIGHEST = coord_type'(32'h7FFF_FFFF);

   typedef struct packed {
      index_type index;
      coord_type min_x, min_y, min_z;
      coord_type max_x, max_y, max_z;
   } box_type;

   typedef struct packed {
      index_type                 source;
      logic                      valid;
      logic [PIECE_NUM_BITS-1:0] number;
      coord_type                 min_x, min_y, min_z;
      coord_type                 max_x, max_y, max_z;
      logic                      last;
   } piece_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_SUB_MIN_X;
   coord_type     csr_wdata = '0;
   logic          req_push = 1'b0;
   logic          req_full;
   box_type       req_box = '0;
   logic          rsp_empty;
   logic          rsp_pop = 1'b0;
   index_type     rsp_source_index;
   logic          rsp_piece_valid;
   logic [PIECE_NUM_BITS-1:0] rsp_piece_number;
   coord_type     rsp_piece_min_x, rsp_piece_min_y, rsp_piece_min_z;
   coord_type     rsp_piece_max_x, rsp_piece_max_y, rsp_piece_max_z;
   logic          rsp_last_piece;

   // Request source, expected pieces and the subtract box as last written
   box_type   box_queue[$];
   piece_type pieces_due[$];
   coord_type cut_lo[3] = '{0, 0, 0};
   coord_type cut_hi[3] = '{0, 0, 0};
   logic      req_fired = 1'b0;
   int        send_idle_pct = 20;
   int        recv_idle_pct = 61;
   int        mismatches = 0;
   int        cycle_count = 0;

   axis_box_subtract_split dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_box_index    (req_box.index),
      .req_box_min_x    (req_box.min_x),
      .req_box_min_y    (req_box.min_y),
      .req_box_min_z    (req_box.min_z),
      .req_box_max_x    (req_box.max_x),
      .req_box_max_y    (req_box.max_y),
      .req_box_max_z    (req_box.max_z),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_source_index (rsp_source_index),
      .rsp_piece_valid  (rsp_piece_valid),
      .rsp_piece_number (rsp_piece_number),
      .rsp_piece_min_x  (rsp_piece_min_x),
      .rsp_piece_min_y  (rsp_piece_min_y),
      .rsp_piece_min_z  (rsp_piece_min_z),
      .rsp_piece_max_x  (rsp_piece_max_x),
      .rsp_piece_max_y  (rsp_piece_max_y),
      .rsp_piece_max_z  (rsp_piece_max_z),
      .rsp_last_piece   (rsp_last_piece)
   );

   always #2 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Strictly positive extent on every axis
   function automatic logic is_solid(input coord_type lo[3], input coord_type hi[3]);
      return lo[0] < hi[0] && lo[1] < hi[1] && lo[2] < hi[2];
   endfunction

   // Pieces left once the subtract box is cut out of one request
   function automatic void predict_pieces(input box_type b);
      coord_type blo[3], bhi[3], ilo[3], ihi[3], plo[3], phi[3];
      piece_type found[NUM_PIECES];
      piece_type p;
      int        count;
      count  = 0;
      blo[0] = b.min_x;  blo[1] = b.min_y;  blo[2] = b.min_z;
      bhi[0] = b.max_x;  bhi[1] = b.max_y;  bhi[2] = b.max_z;
      for (int a = 0; a < NUM_AXES; a++) begin
         ilo[a] = (cut_lo[a] > blo[a]) ? cut_lo[a] : blo[a];
         ihi[a] = (cut_hi[a] < bhi[a]) ? cut_hi[a] : bhi[a];
      end
      // no overlap (touching included): the box stays, nothing comes out
      if (!is_solid(ilo, ihi))
         return;
      // lower then upper slab, axis by axis
      for (int k = 0; k < NUM_AXES; k++) begin
         for (int side = 0; side < 2; side++) begin
            plo = blo;
            phi = bhi;
            if (side == 0)
               phi[k] = ilo[k];
            else
               plo[k] = ihi[k];
            if (is_solid(plo, phi)) begin
               p        = '0;
               p.source = b.index;
               p.valid  = 1'b1;
               p.number = PIECE_NUM_BITS'(count);
               p.min_x  = plo[0];  p.min_y = plo[1];  p.min_z = plo[2];
               p.max_x  = phi[0];  p.max_y = phi[1];  p.max_z = phi[2];
               found[count] = p;
               count++;
            end
         end
      end
      if (count == 0) begin
         // swallowed whole: a single removal marker
         p        = '0;
         p.source = b.index;
         p.last   = 1'b1;
         pieces_due.insert(pieces_due.size(), p);
      end else begin
         found[count-1].last = 1'b1;
         for (int i = 0; i < count; i++)
            pieces_due.insert(pieces_due.size(), found[i]);
      end
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Request driver: new values at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop  <= 1'b0;
      end else begin
         if (!req_push || req_fired) begin
            if (box_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_box  <= box_queue.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on accepted requests, check popped results
   always @(posedge clock) begin
      piece_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_push && !req_full;
         if (req_push && !req_full)
            predict_pieces(req_box);
         if (rsp_pop && !rsp_empty) begin
            if (pieces_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual index %h piece %0d",
                        $time, rsp_source_index, rsp_piece_number);
               mismatches++;
            end else begin
               want = pieces_due.pop_front();
               check_field("source_index", 32'(want.source), 32'(rsp_source_index));
               check_field("piece_valid", 32'(want.valid), 32'(rsp_piece_valid));
               check_field("piece_number", 32'(want.number), 32'(rsp_piece_number));
               check_field("piece_min_x", want.min_x, rsp_piece_min_x);
               check_field("piece_min_y", want.min_y, rsp_piece_min_y);
               check_field("piece_min_z", want.min_z, rsp_piece_min_z);
               check_field("piece_max_x", want.max_x, rsp_piece_max_x);
               check_field("piece_max_y", want.max_y, rsp_piece_max_y);
               check_field("piece_max_z", want.max_z, rsp_piece_max_z);
               check_field("last_piece", 32'(want.last), 32'(rsp_last_piece));
            end
         end
      end
   end

   task automatic csr_write(input csr_index_type idx, input coord_type value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      case (idx)
         CSR_SUB_MIN_X: cut_lo[0] = value;
         CSR_SUB_MIN_Y: cut_lo[1] = value;
         CSR_SUB_MIN_Z: cut_lo[2] = value;
         CSR_SUB_MAX_X: cut_hi[0] = value;
         CSR_SUB_MAX_Y: cut_hi[1] = value;
         CSR_SUB_MAX_Z: cut_hi[2] = value;
         default: ;
      endcase
   endtask

   task automatic set_cut_box(input coord_type lx, ly, lz, hx, hy, hz);
      csr_write(CSR_SUB_MIN_X, lx);
      csr_write(CSR_SUB_MIN_Y, ly);
      csr_write(CSR_SUB_MIN_Z, lz);
      csr_write(CSR_SUB_MAX_X, hx);
      csr_write(CSR_SUB_MAX_Y, hy);
      csr_write(CSR_SUB_MAX_Z, hz);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Quiet point: every request sent, every piece seen, misses flushed through
   task automatic settle();
      while (box_queue.size() != 0 || req_push || pieces_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void queue_box(input index_type idx,
                                     input coord_type lx, ly, lz, hx, hy, hz);
      box_type b;
      b = '{idx, lx, ly, lz, hx, hy, hz};
      box_queue.insert(box_queue.size(), b);
   endfunction

   // Coordinate biased towards the subtract box faces, with some wild values
   function automatic coord_type coord_near(input coord_type lo_c, input coord_type hi_c);
      longint span;
      case ($urandom_range(9))
         0: return lo_c;
         1: return hi_c;
         2, 3: return lo_c + coord_type'($urandom_range(64)) - 32;
         4, 5: return hi_c + coord_type'($urandom_range(64)) - 32;
         6: return coord_type'($urandom);
         7: return COORD_LOWEST;
         8: return COORD_HIGHEST;
         default: begin
            span = longint'(hi_c) - longint'(lo_c);
            if (span <= 0)
               return lo_c;
            return coord_type'(longint'(lo_c) + (longint'($urandom) % span));
         end
      endcase
   endfunction

   // Mostly well-ordered boxes around the subtract box, a few inverted
   function automatic box_type random_box();
      box_type   b;
      coord_type p, q;
      coord_type lo3[3], hi3[3];
      for (int a = 0; a < NUM_AXES; a++) begin
         p = coord_near(cut_lo[a], cut_hi[a]);
         q = coord_near(cut_lo[a], cut_hi[a]);
         if ($urandom_range(9) != 0 && p > q) begin
            lo3[a] = q;
            hi3[a] = p;
         end else begin
            lo3[a] = p;
            hi3[a] = q;
         end
      end
      b = '{index_type'($urandom), lo3[0], lo3[1], lo3[2], hi3[0], hi3[1], hi3[2]};
      return b;
   endfunction

   // Stimulus sequencing
   initial begin
      coord_type lo[3], hi[3];
      int        axis;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // reset subtract box is zero-sized: nothing may come out
      queue_box(16'h0001, -Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE);
      queue_box(16'h0002, COORD_LOWEST, COORD_LOWEST, COORD_LOWEST,
                COORD_HIGHEST, COORD_HIGHEST, COORD_HIGHEST);
      settle();

      // directed set against a 20-unit cube at the origin
      set_cut_box(-10*Q_ONE, -10*Q_ONE, -10*Q_ONE, 10*Q_ONE, 10*Q_ONE, 10*Q_ONE);
      // fully covered: removal marker
      queue_box(16'h0000, -5*Q_ONE, -5*Q_ONE, -5*Q_ONE, 5*Q_ONE, 5*Q_ONE, 5*Q_ONE);
      // enclosing: all six slabs
      queue_box(16'hFFFF, -20*Q_ONE, -20*Q_ONE, -20*Q_ONE, 20*Q_ONE, 20*Q_ONE, 20*Q_ONE);
      // touching on a face
      queue_box(16'h0010, 10*Q_ONE, -20*Q_ONE, -20*Q_ONE, 20*Q_ONE, 20*Q_ONE, 20*Q_ONE);
      // disjoint
      queue_box(16'h0011, 30*Q_ONE, -20*Q_ONE, -20*Q_ONE, 40*Q_ONE, 20*Q_ONE, 20*Q_ONE);
      // inverted and flat requests
      queue_box(16'h0012, 5*Q_ONE, -20*Q_ONE, -20*Q_ONE, -5*Q_ONE, 20*Q_ONE, 20*Q_ONE);
      queue_box(16'h0013, -20*Q_ONE, 0, -20*Q_ONE, 20*Q_ONE, 0, 20*Q_ONE);
      // whole coordinate range
      queue_box(16'h8000, COORD_LOWEST, COORD_LOWEST, COORD_LOWEST,
                COORD_HIGHEST, COORD_HIGHEST, COORD_HIGHEST);
      // single slabs on x and y, one per side; both z slabs from one box
      queue_box(16'h0020, 0, -5*Q_ONE, -5*Q_ONE, 20*Q_ONE, 5*Q_ONE, 5*Q_ONE);
      queue_box(16'h0021, -5*Q_ONE, -20*Q_ONE, -5*Q_ONE, 5*Q_ONE, 0, 5*Q_ONE);
      queue_box(16'h0022, -5*Q_ONE, -5*Q_ONE, -20*Q_ONE, 5*Q_ONE, 5*Q_ONE, 20*Q_ONE);
      queue_box(16'h0023, -20*Q_ONE, -5*Q_ONE, -5*Q_ONE, 0, 5*Q_ONE, 5*Q_ONE);
      queue_box(16'h0024, -5*Q_ONE, 0, -5*Q_ONE, 5*Q_ONE, 20*Q_ONE, 5*Q_ONE);
      // bit patterns in index and coordinates
      queue_box(16'hAAAA, COORD_LOWEST, -1, -1, COORD_HIGHEST, 1, Q_ONE);
      queue_box(16'h5555, -1, COORD_LOWEST, coord_type'(32'h5555_5555),
                0, COORD_HIGHEST, coord_type'(32'h7AAA_AAAA));
      // faces coincide with the cut on x: four slabs
      queue_box(16'h0030, -10*Q_ONE, -20*Q_ONE, -20*Q_ONE, 10*Q_ONE, 20*Q_ONE, 20*Q_ONE);
      // overlap of a single LSB
      queue_box(16'h0031, 10*Q_ONE - 1, -20*Q_ONE, -20*Q_ONE, 20*Q_ONE, 20*Q_ONE, 20*Q_ONE);
      queue_box(16'h0032, -11*Q_ONE, -10*Q_ONE - 1, -9*Q_ONE, -9*Q_ONE,
                -10*Q_ONE + 1, 11*Q_ONE);
      settle();

      // random phases, each with a fresh subtract box
      for (int phase = 0; phase < 6; phase++) begin
         send_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 61 : 0;
         recv_idle_pct = (phase < 2) ? 61 : (phase < 4) ? 20 : 0;
         for (int a = 0; a < NUM_AXES; a++) begin
            case (phase)
               1: begin
                  lo[a] = COORD_LOWEST;
                  hi[a] = COORD_HIGHEST;
               end
               2: begin
                  lo[a] = coord_type'($urandom);
                  hi[a] = lo[a] + coord_type'($urandom_range(1, 1 << 20));
               end
               4: begin
                  lo[a] = coord_type'($urandom_range(2000)) * 256 - 256000;
                  hi[a] = lo[a] + 1;
               end
               5: begin
                  lo[a] = coord_type'($urandom);
                  hi[a] = coord_type'($urandom);
                  if (lo[a] > hi[a]) begin
                     lo[a] = lo[a] ^ hi[a];
                     hi[a] = lo[a] ^ hi[a];
                     lo[a] = lo[a] ^ hi[a];
                  end
               end
               default: begin
                  lo[a] = -coord_type'($urandom_range(1000)) * 256;
                  hi[a] = lo[a] + coord_type'($urandom_range(1, 2000)) * 256;
               end
            endcase
         end
         // one axis turned inside out or flat
         if (phase == 3) begin
            axis     = $urandom_range(NUM_AXES - 1);
            hi[axis] = lo[axis] - coord_type'($urandom_range(5));
         end
         set_cut_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
         for (int i = 0; i < PHASE_ITEMS; i++)
            box_queue.insert(box_queue.size(), random_box());
         settle();
      end

      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
